### src/cst_pkg.sv
// package: types, constants and helper functions for the statement tokenizer
package cst_pkg;

  localparam int STMT_BYTES = 1024;
  localparam int MAX_ARGS   = 16;

  localparam int SB_W  = $clog2(STMT_BYTES + 1);
  localparam int ARG_W = $clog2(MAX_ARGS + 1);

  localparam logic [SB_W-1:0]  SB_LIMIT  = SB_W'(STMT_BYTES);
  localparam logic [ARG_W-1:0] ARG_LIMIT = ARG_W'(MAX_ARGS);

  localparam logic [15:0] LINE_MAX = 16'hFFFF;
  localparam logic [3:0]  IDX_MAX  = 4'd15;

  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_DQUOT = 8'd34;
  localparam logic [7:0] CH_HASH  = 8'd35;
  localparam logic [7:0] CH_SQUOT = 8'd39;
  localparam logic [7:0] CH_BSL   = 8'd92;
  localparam logic [7:0] CH_BTICK = 8'd96;
  localparam logic [7:0] CH_LOW_N = 8'd110;
  localparam logic [7:0] CH_LOW_R = 8'd114;
  localparam logic [7:0] CH_LOW_T = 8'd116;

  typedef enum logic [2:0] {
    M_BETWEEN = 3'd0,
    M_COMMENT = 3'd1,
    M_ARGWS   = 3'd2,
    M_TOKEN   = 3'd3,
    M_ESC     = 3'd4,
    M_HEX     = 3'd5,
    M_CONT    = 3'd6,
    M_DISCARD = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    K_BYTE    = 2'd0,
    K_TOK_END = 2'd1,
    K_STMT_END = 2'd2,
    K_ERROR   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    E_TOO_LONG   = 3'd0,
    E_BAD_ESC    = 3'd1,
    E_BAD_HEX    = 3'd2,
    E_SHORT_HEX  = 3'd3,
    E_TRAIL_BSL  = 3'd4,
    E_OPEN_QUOTE = 3'd5,
    E_MANY_ARGS  = 3'd6,
    E_STRAY_BSL  = 3'd7
  } err_t;

  typedef enum logic [1:0] {
    Q_NONE  = 2'd0,
    Q_SINGLE = 2'd1,
    Q_DOUBLE = 2'd2,
    Q_BTICK = 2'd3
  } quote_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  tok_byte;
    err_t        err_code;
    logic [15:0] line_no;
    logic [3:0]  arg_index;
    logic        last;
  } res_t;

  function automatic logic is_nl(input logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT);
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'd48 && c <= 8'd57) r = {1'b1, 4'(c - 8'd48)};
    else if (c >= 8'd97 && c <= 8'd102) r = {1'b1, 4'(c - 8'd87)};
    else if (c >= 8'd65 && c <= 8'd70) r = {1'b1, 4'(c - 8'd55)};
    return r;
  endfunction

  function automatic quote_t quote_code(input logic [7:0] c);
    quote_t q;
    q = Q_NONE;
    if (c == CH_SQUOT) q = Q_SINGLE;
    else if (c == CH_DQUOT) q = Q_DOUBLE;
    else if (c == CH_BTICK) q = Q_BTICK;
    return q;
  endfunction

  function automatic logic [7:0] quote_byte(input quote_t q);
    logic [7:0] b;
    case (q)
      Q_SINGLE: b = CH_SQUOT;
      Q_DOUBLE: b = CH_DQUOT;
      Q_BTICK:  b = CH_BTICK;
      default:  b = 8'd0;
    endcase
    return b;
  endfunction

  function automatic logic [3:0] arg_idx(input logic [ARG_W-1:0] a);
    return (32'(a) > 32'(IDX_MAX)) ? IDX_MAX : 4'(a);
  endfunction

endpackage

### src/config_statement_tokenizer_top.sv
// statement tokenizer: one text byte per word in, token bytes, token ends, statement ends, errors out
// the first result of a byte is registered and offered in the cycle after the byte is accepted
// throughput: one byte per cycle while each byte gives at most one result and the output drains;
//   a byte that gives two results holds the input until the first leaves the two-entry buffer
// reset (synchronous, active low): scanner goes between statements, line counter to one,
//   statement counters to zero, result buffer empty
module config_statement_tokenizer_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_ch,
  input  logic              in_is_end,
  output logic              out_valid,
  input  logic              out_stall,
  output cst_pkg::kind_t    out_kind,
  output logic [7:0]        out_tok_byte,
  output cst_pkg::err_t     out_err_code,
  output logic [15:0]       out_line_no,
  output logic [3:0]        out_arg_index,
  output logic              out_last
);
  import cst_pkg::*;

  // scanner state
  mode_t            mode_r, mode_nxt;
  quote_t           qc_r, qc_nxt;
  logic [3:0]       hh_r, hh_nxt;
  logic             acr_r, acr_nxt;
  logic [15:0]      lc_r, lc_nxt;
  logic [SB_W-1:0]  sb_r, sb_nxt;
  logic [ARG_W-1:0] ac_r, ac_nxt;

  // result buffer: slot 0 is shown, slot 1 waits
  res_t             slot0_r, slot0_nxt;
  res_t             slot1_r, slot1_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  logic             in_fire, out_fire;
  logic             skip, ch_nl, sb_full;
  logic             do_start, do_esc;
  logic             f_store, f_tend, f_send, f_fail, f_nl;
  logic [7:0]       sbyte;
  err_t             fcode;
  quote_t           qc_v, qstart;
  logic [4:0]       hv;
  logic [ARG_W-1:0] ac_tend;
  res_t             r_first, r_second;
  logic [1:0]       r_n;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign in_stall = !((cnt_r == 2'd0) || (cnt_r == 2'd1 && !out_stall));

  assign ch_nl   = is_nl(in_ch);
  assign sb_full = sb_r >= SB_LIMIT;
  assign hv      = hex_val(in_ch);
  assign qstart  = quote_code(in_ch);

  // decide what this word does
  always_comb begin
    mode_nxt = mode_r;
    qc_v     = qc_r;
    hh_nxt   = hh_r;
    acr_nxt  = acr_r;
    skip     = 1'b0;
    do_start = 1'b0;
    do_esc   = 1'b0;
    f_store  = 1'b0;
    f_tend   = 1'b0;
    f_send   = 1'b0;
    f_fail   = 1'b0;
    f_nl     = 1'b0;
    sbyte    = 8'd0;
    fcode    = E_TOO_LONG;

    if (in_is_end) begin
      case (mode_r)
        M_TOKEN: begin
          if (qc_r != Q_NONE) begin
            f_fail = 1'b1;
            fcode  = E_OPEN_QUOTE;
          end else begin
            f_tend = 1'b1;
            f_send = 1'b1;
          end
        end
        M_ESC: begin
          f_fail = 1'b1;
          fcode  = E_TRAIL_BSL;
        end
        M_HEX: begin
          f_fail = 1'b1;
          fcode  = E_SHORT_HEX;
        end
        M_CONT: begin
          f_fail = 1'b1;
          fcode  = (ac_r != '0) ? E_STRAY_BSL : E_TRAIL_BSL;
        end
        M_ARGWS: f_send = 1'b1;
        default: ;
      endcase
    end else begin
      // LF right after CR is part of the same line break
      if (acr_r) begin
        acr_nxt = 1'b0;
        skip    = (in_ch == CH_LF);
      end
      if (!skip) begin
        case (mode_r)
          M_BETWEEN: begin
            if (ch_nl) f_nl = 1'b1;
            else if (is_blank(in_ch)) ;
            else if (in_ch == CH_HASH) mode_nxt = M_COMMENT;
            else if (in_ch == CH_BSL) mode_nxt = M_CONT;
            else do_start = 1'b1;
          end
          M_COMMENT, M_DISCARD: begin
            if (ch_nl) begin
              f_nl     = 1'b1;
              mode_nxt = M_BETWEEN;
            end
          end
          M_ARGWS: begin
            if (is_blank(in_ch)) ;
            else if (ch_nl) begin
              f_send   = 1'b1;
              f_nl     = 1'b1;
              mode_nxt = M_BETWEEN;
            end else if (in_ch == CH_HASH) begin
              f_send   = 1'b1;
              mode_nxt = M_COMMENT;
            end else if (in_ch == CH_BSL) mode_nxt = M_CONT;
            else do_start = 1'b1;
          end
          M_TOKEN: begin
            if (sb_full) begin
              f_fail = 1'b1;
              fcode  = E_TOO_LONG;
            end else if (qc_r != Q_NONE) begin
              if (in_ch == quote_byte(qc_r)) begin
                f_tend   = 1'b1;
                qc_v     = Q_NONE;
                mode_nxt = M_ARGWS;
              end else if (in_ch == CH_VT || ch_nl) begin
                f_fail = 1'b1;
                fcode  = E_OPEN_QUOTE;
              end else if (in_ch == CH_BSL) mode_nxt = M_ESC;
              else begin
                f_store = 1'b1;
                sbyte   = in_ch;
              end
            end else begin
              if (is_blank(in_ch)) begin
                f_tend   = 1'b1;
                mode_nxt = M_ARGWS;
              end else if (in_ch == CH_HASH) begin
                f_tend   = 1'b1;
                f_send   = 1'b1;
                mode_nxt = M_COMMENT;
              end else if (ch_nl) begin
                f_tend   = 1'b1;
                f_send   = 1'b1;
                f_nl     = 1'b1;
                mode_nxt = M_BETWEEN;
              end else if (in_ch == CH_BSL) mode_nxt = M_ESC;
              else begin
                f_store = 1'b1;
                sbyte   = in_ch;
              end
            end
          end
          M_ESC: do_esc = 1'b1;
          M_HEX: begin
            if (hv[4]) begin
              f_store = 1'b1;
              sbyte   = {hh_r, hv[3:0]};
            end else begin
              f_fail = 1'b1;
              fcode  = E_BAD_HEX;
            end
          end
          M_CONT: begin
            if (ch_nl) begin
              f_nl     = 1'b1;
              mode_nxt = (ac_r != '0) ? M_ARGWS : M_BETWEEN;
            end else if (ac_r != '0) begin
              f_fail = 1'b1;
              fcode  = E_STRAY_BSL;
            end else begin
              // backslash opening a command is an escape
              qc_v   = Q_NONE;
              do_esc = 1'b1;
            end
          end
          default: mode_nxt = M_BETWEEN;
        endcase

        if (do_start) begin
          if (ac_r >= ARG_LIMIT) begin
            f_fail = 1'b1;
            fcode  = E_MANY_ARGS;
          end else if (qstart != Q_NONE) begin
            qc_v     = qstart;
            mode_nxt = M_TOKEN;
          end else if (sb_full) begin
            f_fail = 1'b1;
            fcode  = E_TOO_LONG;
          end else begin
            qc_v    = Q_NONE;
            f_store = 1'b1;
            sbyte   = in_ch;
          end
        end

        if (do_esc) begin
          if (ch_nl) begin
            f_nl = 1'b1;
            if (qc_v != Q_NONE) mode_nxt = M_TOKEN;
            else begin
              // unquoted backslash-newline ends the token, statement goes on
              f_tend   = 1'b1;
              mode_nxt = M_ARGWS;
            end
          end else begin
            case (in_ch)
              CH_LOW_R: begin
                f_store = 1'b1;
                sbyte   = CH_CR;
              end
              CH_LOW_N: begin
                f_store = 1'b1;
                sbyte   = CH_LF;
              end
              CH_LOW_T: begin
                f_store = 1'b1;
                sbyte   = CH_TAB;
              end
              CH_BSL, CH_SQUOT, CH_DQUOT, CH_BTICK: begin
                f_store = 1'b1;
                sbyte   = in_ch;
              end
              default: begin
                if (hv[4]) begin
                  hh_nxt   = hv[3:0];
                  mode_nxt = M_HEX;
                end else begin
                  f_fail = 1'b1;
                  fcode  = E_BAD_ESC;
                end
              end
            endcase
          end
        end

        if (f_store) mode_nxt = M_TOKEN;
        if (f_tend) qc_v = Q_NONE;

        // an error on a newline resumes at once, else skip to end of line
        if (f_fail) begin
          if (ch_nl) begin
            f_nl     = 1'b1;
            mode_nxt = M_BETWEEN;
          end else begin
            mode_nxt = M_DISCARD;
          end
        end
      end
    end
  end

  // counters and statement clear
  always_comb begin
    ac_tend = (f_tend && ac_r < ARG_LIMIT) ? ac_r + 1'b1 : ac_r;
    ac_nxt  = ac_tend;
    sb_nxt  = ((f_store || f_tend) && !sb_full) ? sb_r + 1'b1 : sb_r;
    qc_nxt  = qc_v;
    lc_nxt  = lc_r;
    if (f_nl) begin
      if (lc_r != LINE_MAX) lc_nxt = lc_r + 16'd1;
    end
    if (f_fail || f_send) begin
      ac_nxt = '0;
      sb_nxt = '0;
      qc_nxt = Q_NONE;
    end
  end

  // results of this word
  always_comb begin
    r_first           = '0;
    r_first.line_no   = lc_r;
    r_first.arg_index = arg_idx(ac_r);
    r_second          = r_first;
    r_n               = 2'd0;
    if (f_store) begin
      r_first.kind     = K_BYTE;
      r_first.tok_byte = sbyte;
      r_n              = 2'd1;
    end else if (f_fail) begin
      r_first.kind     = K_ERROR;
      r_first.err_code = fcode;
      r_n              = 2'd1;
    end else if (f_tend) begin
      r_first.kind = K_TOK_END;
      r_n          = 2'd1;
      if (f_send) begin
        r_second.kind      = K_STMT_END;
        r_second.arg_index = arg_idx((ac_tend != '0) ? ac_tend - 1'b1 : '0);
        r_n                = 2'd2;
      end
    end else if (f_send) begin
      r_first.kind      = K_STMT_END;
      r_first.arg_index = arg_idx((ac_r != '0) ? ac_r - 1'b1 : '0);
      r_n               = 2'd1;
    end
    r_first.last  = (r_n == 2'd1);
    r_second.last = 1'b1;
  end

  // buffer refill and drain
  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    cnt_nxt   = cnt_r;
    if (in_fire) begin
      slot0_nxt = r_first;
      slot1_nxt = r_second;
      cnt_nxt   = r_n;
    end else if (out_fire) begin
      slot0_nxt = slot1_r;
      cnt_nxt   = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_BETWEEN;
      qc_r   <= Q_NONE;
      hh_r   <= 4'd0;
      acr_r  <= 1'b0;
      lc_r   <= 16'd1;
      sb_r   <= '0;
      ac_r   <= '0;
      cnt_r  <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_fire) begin
        if (in_is_end) begin
          mode_r <= M_BETWEEN;
          qc_r   <= Q_NONE;
          hh_r   <= 4'd0;
          acr_r  <= 1'b0;
          lc_r   <= 16'd1;
          sb_r   <= '0;
          ac_r   <= '0;
        end else begin
          mode_r <= mode_nxt;
          qc_r   <= qc_nxt;
          hh_r   <= (f_fail || f_send) ? 4'd0 : hh_nxt;
          acr_r  <= f_nl ? (in_ch == CH_CR) : acr_nxt;
          lc_r   <= lc_nxt;
          sb_r   <= sb_nxt;
          ac_r   <= ac_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  assign out_valid     = (cnt_r != 2'd0);
  assign out_kind      = slot0_r.kind;
  assign out_tok_byte  = slot0_r.tok_byte;
  assign out_err_code  = slot0_r.err_code;
  assign out_line_no   = slot0_r.line_no;
  assign out_arg_index = slot0_r.arg_index;
  assign out_last      = slot0_r.last;

`ifndef SYNTH
  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_line_no != 16'd0)
    else $error("result with line number zero");

  a_err_code_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != K_ERROR |-> out_err_code == E_TOO_LONG)
    else $error("error code set on a non-error result");

  a_last_matches_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (cnt_r == 2'd1)))
    else $error("last flag disagrees with buffer fill");

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_is_end |=> mode_r == M_BETWEEN && lc_r == 16'd1 && ac_r == '0)
    else $error("end marker did not return scanner to start");

  a_bytes_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    sb_r <= SB_LIMIT && ac_r <= ARG_LIMIT)
    else $error("statement counters past their limits");
`endif

endmodule

### bench/tb_config_statement_tokenizer_top.sv
// testbench for the statement tokenizer: directed and random text checked word by word
module tb_config_statement_tokenizer_top;
  import cst_pkg::*;

  // err_code reads zero on every word that is not an error
  localparam err_t NO_ERR = E_TOO_LONG;

  class statement_lexer;
    mode_t       mode;
    quote_t      quote;
    logic [3:0]  hex_hi;
    bit          after_cr;
    logic [15:0] line_cnt;
    int          stmt_cnt;
    int          argc;
    res_t        step_words[$];
    res_t        lexed_words[$];
    int          mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      mode = M_BETWEEN;
      quote = Q_NONE;
      hex_hi = 4'd0;
      after_cr = 1'b0;
      line_cnt = 16'd1;
      stmt_cnt = 0;
      argc = 0;
    endfunction

    function bit is_line_break(logic [7:0] c);
      return c == CH_CR || c == CH_LF;
    endfunction

    function bit is_space(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_VT;
    endfunction

    function int hex_digit(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
    endfunction

    function quote_t quote_of(logic [7:0] c);
      case (c)
        CH_SQUOT: return Q_SINGLE;
        CH_DQUOT: return Q_DOUBLE;
        CH_BTICK: return Q_BTICK;
        default:  return Q_NONE;
      endcase
    endfunction

    function logic [7:0] closer(quote_t q);
      case (q)
        Q_SINGLE: return CH_SQUOT;
        Q_DOUBLE: return CH_DQUOT;
        Q_BTICK:  return CH_BTICK;
        default:  return 8'd0;
      endcase
    endfunction

    function void emit(kind_t k, logic [7:0] b, err_t e, int idx);
      res_t r;
      if (step_words.size() >= 3) return;
      r.kind = k;
      r.tok_byte = b;
      r.err_code = e;
      r.line_no = line_cnt;
      r.arg_index = (idx > int'(IDX_MAX)) ? IDX_MAX : 4'(idx);
      r.last = 1'b0;
      step_words.push_back(r);
    endfunction

    function void bump_line(logic [7:0] c);
      if (line_cnt != LINE_MAX) line_cnt++;
      after_cr = (c == CH_CR);
    endfunction

    function void clear_stmt();
      argc = 0;
      stmt_cnt = 0;
      quote = Q_NONE;
      hex_hi = 4'd0;
    endfunction

    // an error ends the statement; the rest of the line is dropped
    function void fail(err_t e, logic [7:0] c);
      emit(K_ERROR, 8'd0, e, argc);
      clear_stmt();
      if (is_line_break(c)) begin
        bump_line(c);
        mode = M_BETWEEN;
      end else begin
        mode = M_DISCARD;
      end
    endfunction

    function void count_byte();
      if (stmt_cnt < STMT_BYTES) stmt_cnt++;
    endfunction

    function void keep(logic [7:0] b);
      emit(K_BYTE, b, NO_ERR, argc);
      count_byte();
      mode = M_TOKEN;
    endfunction

    function void close_token();
      emit(K_TOK_END, 8'd0, NO_ERR, argc);
      count_byte();
      if (argc < MAX_ARGS) argc++;
      quote = Q_NONE;
      mode = M_ARGWS;
    endfunction

    function void close_stmt();
      emit(K_STMT_END, 8'd0, NO_ERR, (argc != 0) ? argc - 1 : 0);
      clear_stmt();
    endfunction

    function void open_token(logic [7:0] c);
      quote_t q;
      if (argc >= MAX_ARGS) begin
        fail(E_MANY_ARGS, c);
        return;
      end
      q = quote_of(c);
      if (q != Q_NONE) begin
        quote = q;
        mode = M_TOKEN;
        return;
      end
      if (stmt_cnt >= STMT_BYTES) begin
        fail(E_TOO_LONG, c);
        return;
      end
      quote = Q_NONE;
      keep(c);
    endfunction

    function void after_backslash(logic [7:0] c);
      int v;
      if (is_line_break(c)) begin
        // inside quotes the token goes on, outside it ends and the statement goes on
        if (quote != Q_NONE) begin
          bump_line(c);
          mode = M_TOKEN;
        end else begin
          close_token();
          bump_line(c);
        end
        return;
      end
      case (c)
        CH_LOW_R: keep(CH_CR);
        CH_LOW_N: keep(CH_LF);
        CH_LOW_T: keep(CH_TAB);
        CH_BSL, CH_SQUOT, CH_DQUOT, CH_BTICK: keep(c);
        default: begin
          v = hex_digit(c);
          if (v >= 0) begin
            hex_hi = 4'(v);
            mode = M_HEX;
          end else begin
            fail(E_BAD_ESC, c);
          end
        end
      endcase
    endfunction

    function void in_token(logic [7:0] c);
      if (stmt_cnt >= STMT_BYTES) begin
        fail(E_TOO_LONG, c);
        return;
      end
      if (quote != Q_NONE) begin
        if (c == closer(quote)) close_token();
        else if (c == CH_VT || is_line_break(c)) fail(E_OPEN_QUOTE, c);
        else if (c == CH_BSL) mode = M_ESC;
        else keep(c);
        return;
      end
      if (is_space(c)) begin
        close_token();
      end else if (c == CH_HASH) begin
        close_token();
        close_stmt();
        mode = M_COMMENT;
      end else if (is_line_break(c)) begin
        close_token();
        close_stmt();
        bump_line(c);
        mode = M_BETWEEN;
      end else if (c == CH_BSL) begin
        mode = M_ESC;
      end else begin
        keep(c);
      end
    endfunction

    function void step_byte(logic [7:0] c);
      int v;
      case (mode)
        M_BETWEEN: begin
          if (is_line_break(c)) bump_line(c);
          else if (is_space(c)) ;
          else if (c == CH_HASH) mode = M_COMMENT;
          else if (c == CH_BSL) mode = M_CONT;
          else open_token(c);
        end
        M_COMMENT, M_DISCARD: begin
          if (is_line_break(c)) begin
            bump_line(c);
            mode = M_BETWEEN;
          end
        end
        M_ARGWS: begin
          if (is_space(c)) ;
          else if (is_line_break(c)) begin
            close_stmt();
            bump_line(c);
            mode = M_BETWEEN;
          end else if (c == CH_HASH) begin
            close_stmt();
            mode = M_COMMENT;
          end else if (c == CH_BSL) begin
            mode = M_CONT;
          end else begin
            open_token(c);
          end
        end
        M_TOKEN: in_token(c);
        M_ESC: after_backslash(c);
        M_HEX: begin
          v = hex_digit(c);
          if (v >= 0) keep({hex_hi, 4'(v)});
          else fail(E_BAD_HEX, c);
        end
        default: begin
          // backslash outside a token: continuation, stray, or escape at command start
          if (is_line_break(c)) begin
            bump_line(c);
            mode = (argc != 0) ? M_ARGWS : M_BETWEEN;
          end else if (argc != 0) begin
            fail(E_STRAY_BSL, c);
          end else begin
            quote = Q_NONE;
            after_backslash(c);
          end
        end
      endcase
    endfunction

    function void lex_word(logic [7:0] ch, logic is_end);
      bit skip;
      step_words.delete();
      if (is_end) begin
        case (mode)
          M_TOKEN: begin
            if (quote != Q_NONE) begin
              fail(E_OPEN_QUOTE, 8'd0);
            end else begin
              close_token();
              close_stmt();
            end
          end
          M_ESC: fail(E_TRAIL_BSL, 8'd0);
          M_HEX: fail(E_SHORT_HEX, 8'd0);
          M_CONT: fail((argc != 0) ? E_STRAY_BSL : E_TRAIL_BSL, 8'd0);
          M_ARGWS: close_stmt();
          default: ;
        endcase
        restart();
      end else begin
        skip = 1'b0;
        // lf right after cr belongs to the same line break
        if (after_cr) begin
          after_cr = 1'b0;
          if (ch == CH_LF) skip = 1'b1;
        end
        if (!skip) step_byte(ch);
      end
      if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
      foreach (step_words[i]) lexed_words.push_back(step_words[i]);
    endfunction

    function void cmp_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_word(res_t got);
      res_t want;
      if (lexed_words.size() == 0) begin
        $error("word with nothing pending: kind %0d, line %0d", got.kind, got.line_no);
        mismatches++;
        return;
      end
      want = lexed_words.pop_front();
      cmp_field("kind", want.kind, got.kind);
      cmp_field("tok_byte", want.tok_byte, got.tok_byte);
      cmp_field("err_code", want.err_code, got.err_code);
      cmp_field("line_no", want.line_no, got.line_no);
      cmp_field("arg_index", want.arg_index, got.arg_index);
      cmp_field("last", want.last, got.last);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_ch = 8'd0;
  logic        in_is_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  kind_t       out_kind;
  logic [7:0]  out_tok_byte;
  err_t        out_err_code;
  logic [15:0] out_line_no;
  logic [3:0]  out_arg_index;
  logic        out_last;

  statement_lexer lexer;
  res_t           seen;
  logic [7:0]     line_bytes[$];
  int             idle_pct = 30;
  int             stall_pct = 72;
  int             sent = 0;

  config_statement_tokenizer_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_ch(in_ch),
    .in_is_end(in_is_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_tok_byte(out_tok_byte),
    .out_err_code(out_err_code),
    .out_line_no(out_line_no),
    .out_arg_index(out_arg_index),
    .out_last(out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        seen.kind = out_kind;
        seen.tok_byte = out_tok_byte;
        seen.err_code = out_err_code;
        seen.line_no = out_line_no;
        seen.arg_index = out_arg_index;
        seen.last = out_last;
        lexer.check_word(seen);
      end
      if (in_valid && in_stall === 1'b0) lexer.lex_word(in_ch, in_is_end);
    end
  end

  task automatic send_item(input logic [7:0] c, input logic e);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      in_ch <= 8'($urandom);
      in_is_end <= 1'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_ch <= c;
    in_is_end <= e;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic flush_text();
    while (line_bytes.size() != 0) send_item(line_bytes.pop_front(), 1'b0);
  endtask

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
  endfunction

  function automatic void push_newline();
    case ($urandom_range(2))
      0: line_bytes.push_back(CH_LF);
      1: line_bytes.push_back(CH_CR);
      default: begin
        line_bytes.push_back(CH_CR);
        line_bytes.push_back(CH_LF);
      end
    endcase
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(2))
      0: return CH_SPACE;
      1: return CH_TAB;
      default: return CH_VT;
    endcase
  endfunction

  function automatic logic [7:0] hex_char();
    string digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(21)];
  endfunction

  // a byte with no special meaning where it lands
  function automatic logic [7:0] plain_byte(bit quoted, bit first, logic [7:0] stop);
    logic [7:0] c;
    bit         bad;
    do begin
      c = ($urandom_range(9) < 8) ? 8'($urandom_range(126, 33)) : 8'($urandom);
      bad = c == CH_BSL || c == CH_LF || c == CH_CR || c == CH_VT;
      if (quoted) bad = bad || c == stop;
      else bad = bad || c == CH_SPACE || c == CH_TAB || c == CH_HASH ||
                 (first && (c == CH_SQUOT || c == CH_DQUOT || c == CH_BTICK));
    end while (bad);
    return c;
  endfunction

  function automatic void push_escape();
    logic [7:0] simple[7] = '{CH_LOW_R, CH_LOW_N, CH_LOW_T, CH_BSL, CH_SQUOT, CH_DQUOT,
                              CH_BTICK};
    string      wrong = "gGxz?!~";
    int         r;
    r = $urandom_range(19);
    line_bytes.push_back(CH_BSL);
    if (r < 7) begin
      line_bytes.push_back(simple[r]);
    end else if (r < 13) begin
      line_bytes.push_back(hex_char());
      line_bytes.push_back(hex_char());
    end else if (r == 13) begin
      line_bytes.push_back(wrong[$urandom_range(6)]);
    end else if (r == 14) begin
      line_bytes.push_back(hex_char());
      case ($urandom_range(2))
        0: line_bytes.push_back("g");
        1: line_bytes.push_back(CH_SPACE);
        default: line_bytes.push_back(CH_LF);
      endcase
    end else begin
      push_newline();
    end
  endfunction

  function automatic void push_comment();
    logic [7:0] c;
    line_bytes.push_back(CH_HASH);
    repeat ($urandom_range(6)) begin
      do c = 8'($urandom); while (c == CH_CR || c == CH_LF);
      line_bytes.push_back(c);
    end
    push_newline();
  endfunction

  function automatic void push_gap();
    repeat ($urandom_range(1, 3)) line_bytes.push_back(blank_char());
    if ($urandom_range(9) == 0) begin
      line_bytes.push_back(CH_BSL);
      push_newline();
    end
  endfunction

  function automatic void push_token();
    logic [7:0] quotes[3] = '{CH_SQUOT, CH_DQUOT, CH_BTICK};
    logic [7:0] q;
    if ($urandom_range(9) < 4) begin
      q = quotes[$urandom_range(2)];
      line_bytes.push_back(q);
      repeat ($urandom_range(6)) begin
        if ($urandom_range(9) < 3) push_escape();
        else line_bytes.push_back(plain_byte(1'b1, 1'b0, q));
      end
      // now and then the quote is left open
      if ($urandom_range(19) != 0) line_bytes.push_back(q);
    end else begin
      if ($urandom_range(19) == 0) push_escape();
      else line_bytes.push_back(plain_byte(1'b0, 1'b1, 8'd0));
      repeat ($urandom_range(5)) begin
        if ($urandom_range(9) < 2) push_escape();
        else line_bytes.push_back(plain_byte(1'b0, 1'b0, 8'd0));
      end
    end
  endfunction

  function automatic void push_statement();
    int r;
    int n;
    int i;
    r = $urandom_range(99);
    if (r < 8) begin
      repeat ($urandom_range(1, 8)) line_bytes.push_back(8'($urandom));
      push_newline();
      return;
    end
    if (r < 12) begin
      if (r[0]) line_bytes.push_back(blank_char());
      push_comment();
      return;
    end
    if (r < 15) begin
      line_bytes.push_back(CH_BSL);
      push_newline();
    end
    if ($urandom_range(3) == 0) line_bytes.push_back(blank_char());
    r = $urandom_range(99);
    n = (r < 80) ? $urandom_range(1, 4) : (r < 95) ? $urandom_range(5, 16) :
        $urandom_range(17, 18);
    for (i = 0; i < n; i++) begin
      if (i > 0) push_gap();
      push_token();
    end
    r = $urandom_range(3);
    if (r == 0) line_bytes.push_back(blank_char());
    if (r == 1) push_comment();
    else push_newline();
  endfunction

  task automatic random_text(input int budget);
    int start;
    int k;
    start = sent;
    while (sent - start < budget) begin
      push_statement();
      if ($urandom_range(19) == 0) begin
        // buffer ends partway through a statement
        k = $urandom_range(line_bytes.size() - 1);
        while (line_bytes.size() > k + 1) void'(line_bytes.pop_back());
        flush_text();
        send_item(8'($urandom), 1'b1);
      end else begin
        flush_text();
        if ($urandom_range(11) == 0) send_item(8'($urandom), 1'b1);
      end
    end
  endtask

  initial begin
    #12_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    lexer = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // extreme bytes as a token, cr lf as one line break
    line_bytes.push_back(8'hFF);
    line_bytes.push_back(8'h00);
    line_bytes.push_back(CH_CR);
    line_bytes.push_back(CH_LF);
    // quoted escapes, continuation between args, backquote token, comment
    push_str("\"\\41\\n\" \\\n");
    line_bytes.push_back(CH_BTICK);
    push_str("b");
    line_bytes.push_back(CH_BTICK);
    push_str(" #x\n");
    flush_text();
    send_item(8'hFF, 1'b1);
    // trailing backslash at the end of the buffer
    push_str("\\");
    flush_text();
    send_item(8'h00, 1'b1);

    random_text(125);
    idle_pct = 72;
    stall_pct = 30;
    random_text(125);
    idle_pct = 0;
    stall_pct = 0;
    random_text(125);

    // the end marker brings the line counter back to one
    push_str("a b\n");
    flush_text();
    send_item(8'h5A, 1'b1);
    push_str("c\n");
    flush_text();
    in_valid <= 1'b0;

    while (lexer.lexed_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (lexer.mismatches == 0 && lexer.lexed_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
